// ===== hw/rtl/slg_pkg.sv =====
package slg_pkg;

    // Control word from the sequencer to the serial multiply-accumulate unit
    typedef struct packed {
        logic clear;  // preload accumulator with the rounding constant
        logic load;   // load multiplicand and serial multiplier
        logic step;   // consume one multiplier bit
    } mac_ctl_t;

    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_GATE_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TREBLE_RETAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASS_RETAIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK_STEP    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WET_MIX        = 3'd4;

endpackage

// ===== hw/rtl/slg_stream_if.sv =====
interface slg_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface slg_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== hw/rtl/slg_mac.sv =====
// Bit-serial multiply-accumulate: one multiplier bit per cycle while step is asserted, LSB first.
module slg_mac #(
    parameter int AW    = 27,
    parameter int CW    = 26,
    parameter int ACC_W = 55,
    parameter int CF    = 24
) (
    input  logic                    clk,
    input  slg_pkg::mac_ctl_t       ctl,
    input  logic signed [AW-1:0]    a,
    input  logic        [CW-1:0]    c,
    output logic signed [ACC_W-1:0] acc
);

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (CF - 1);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] a_sh_reg;
    logic        [CW-1:0]    c_sh_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_reg <= HALF_LSB;
        end
        else if (ctl.step && c_sh_reg[0])
        begin
            acc_reg <= acc_reg + a_sh_reg;
        end

        if (ctl.load)
        begin
            a_sh_reg <= ACC_W'(a);
            c_sh_reg <= c;
        end
        else if (ctl.step)
        begin
            a_sh_reg <= a_sh_reg <<< 1;
            c_sh_reg <= c_sh_reg >> 1;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hw/rtl/stereo_linked_envelope_gate_top.sv =====
// Channel   | Dir | Payload                   | Handshake
// in_pair   | in  | left_in, right_in         | valid/ready, request taken when both high
// out_pair  | out | left_out, right_out       | valid/ready, held until taken
// cfg       | in  | cfg_we, cfg_index, cfg_data | write on cfg_we, no wait
//
// Each request runs nine multiply-accumulate ops of two products each through
// one bit-serial multiplier: each product is a load followed by a shift per
// multiplier bit (COEF_FRAC_BITS+2 bits), and each op ends with a store. The
// sequencer then returns to idle, and a new request is taken only there.
// Reset zeroes the bass envelope, filter banks, bank select and gate threshold,
// and presets the treble envelope and the other config registers to defaults.
// A finished pair sits in the output register; the next request is taken
// meanwhile, and only the final store waits if that register is still full.
module stereo_linked_envelope_gate_top #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    slg_in_if.sink                                  in_pair,
    slg_out_if.source                               out_pair,
    input  logic                                    cfg_we,
    input  logic [slg_pkg::REG_IDX_W-1:0]           cfg_index,
    input  logic [((SAMPLE_BITS-1) > (COEF_FRAC_BITS+2) ?
                   (SAMPLE_BITS-1) : (COEF_FRAC_BITS+2))-1:0] cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CF    = COEF_FRAC_BITS;
    localparam int CW    = CF + 2;                  // serial multiplier width
    localparam int AW    = (SB > CF + 3) ? SB : CF + 3;
    localparam int ACC_W = AW + CW + 2;
    localparam int CNT_W = $clog2(CW);
    localparam int SHL   = (CF >= SB) ? CF - SB : 0;
    localparam int SHR   = (CF >= SB) ? 0 : SB - CF;
    localparam int HW    = SB + CF + 1;

    localparam logic [CF:0]   ONE_C    = (CF+1)'(1) << CF;
    localparam logic [CF+1:0] ATK_RST  = (CF+2)'(((64'd3 << CF) + 64'd500) / 64'd1000);
    localparam logic signed [ACC_W-1:0] ONE_A  = ACC_W'(1) <<< CF;
    localparam logic signed [ACC_W-1:0] SMAX_A = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN_A = -(ACC_W'(1) <<< (SB - 1));

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // op codes, in execution order
    localparam logic [3:0] OP_ATK  = 4'd0;
    localparam logic [3:0] OP_TDEC = 4'd1;
    localparam logic [3:0] OP_BDEC = 4'd2;
    localparam logic [3:0] OP_LP0  = 4'd3;
    localparam logic [3:0] OP_HP0  = 4'd4;
    localparam logic [3:0] OP_OUT0 = 4'd5;
    localparam logic [3:0] OP_LP1  = 4'd6;
    localparam logic [3:0] OP_HP1  = 4'd7;
    localparam logic [3:0] OP_OUT1 = 4'd8;

    function automatic logic signed [ACC_W-1:0] clamp_env(input logic signed [ACC_W-1:0] v);
        clamp_env = (v < 0) ? '0 : ((v > ONE_A) ? ONE_A : v);
    endfunction

    function automatic logic signed [SB-1:0] sat_s(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v < SMIN_A) ? SMIN_A : ((v > SMAX_A) ? SMAX_A : v);
        sat_s = c[SB-1:0];
    endfunction

    function automatic logic [CF:0] cap_one(input logic [CF:0] v);
        cap_one = (v > ONE_C) ? ONE_C : v;
    endfunction

    // configuration
    logic [SB-2:0] thr_reg;
    logic [CF:0]   treble_ret_reg;
    logic [CF:0]   bass_ret_reg;
    logic [CF+1:0] atk_step_reg;
    logic [CF:0]   wet_reg;

    // state
    logic [CF:0]           t_reg;
    logic [CF:0]           b_reg;
    logic signed [SB-1:0]  lp_reg [4];
    logic signed [SB-1:0]  hp_reg [4];
    logic                  bank_sel_reg;

    // per-request working set
    logic signed [SB-1:0]  x0_reg;
    logic signed [SB-1:0]  x1_reg;
    logic [CF:0]           half_reg;
    logic                  open_reg;
    logic signed [SB-1:0]  y0_reg;

    // sequencer
    logic [1:0]       state_reg;
    logic [3:0]       op_reg;
    logic             term_reg;
    logic [CNT_W-1:0] cnt_reg;

    // output register
    logic                 out_valid_reg;
    logic signed [SB-1:0] out_l_reg;
    logic signed [SB-1:0] out_r_reg;

    // key magnitude
    logic [SB-1:0] mag0;
    logic [SB-1:0] mag1;
    logic [SB-1:0] h_in;
    logic [HW-1:0] half_w;

    always_comb
    begin
        mag0   = in_pair.left_in[SB-1]  ? (~in_pair.left_in  + SB'(1)) : in_pair.left_in;
        mag1   = in_pair.right_in[SB-1] ? (~in_pair.right_in + SB'(1)) : in_pair.right_in;
        h_in   = (mag0 > mag1) ? mag0 : mag1;
        half_w = (HW'(h_in) << SHL) >> SHR;
    end

    // operand select
    logic                  ch;
    logic [1:0]            idx;
    logic signed [SB-1:0]  x_ch;
    logic signed [SB-1:0]  lp_cur;
    logic signed [SB-1:0]  hp_cur;
    logic signed [SB:0]    wdiff;
    logic signed [SB-1:0]  w;
    logic signed [CF+1:0]  t_minus_b;
    logic signed [AW-1:0]  a_sel;
    logic [CW-1:0]         c_sel;

    always_comb
    begin
        ch        = (op_reg >= OP_LP1);
        idx       = {~bank_sel_reg, ch};
        x_ch      = ch ? x1_reg : x0_reg;
        lp_cur    = lp_reg[idx];
        hp_cur    = hp_reg[idx];
        wdiff     = (SB+1)'(lp_cur) - (SB+1)'(hp_cur);
        w         = (t_reg > b_reg) ? sat_s(ACC_W'(wdiff)) : '0;
        t_minus_b = $signed({1'b0, t_reg}) - $signed({1'b0, b_reg});
        a_sel     = '0;
        c_sel     = '0;
        case (op_reg)
            OP_ATK:
            begin
                a_sel = AW'({1'b0, atk_step_reg});
                c_sel = term_reg ? '0 : CW'(ONE_C - half_reg);
            end
            OP_TDEC:
            begin
                a_sel = AW'(t_minus_b);
                c_sel = term_reg ? '0 : CW'(cap_one(treble_ret_reg));
            end
            OP_BDEC:
            begin
                a_sel = AW'(-t_minus_b);
                c_sel = term_reg ? '0 : CW'(cap_one(bass_ret_reg));
            end
            OP_LP0, OP_LP1:
            begin
                a_sel = term_reg ? AW'(x_ch) : AW'(lp_cur);
                c_sel = term_reg ? CW'(t_reg) : CW'(ONE_C - t_reg);
            end
            OP_HP0, OP_HP1:
            begin
                a_sel = term_reg ? AW'(x_ch) : AW'(hp_cur);
                c_sel = term_reg ? CW'(b_reg) : CW'(ONE_C - b_reg);
            end
            OP_OUT0, OP_OUT1:
            begin
                a_sel = term_reg ? AW'(w) : AW'(x_ch);
                c_sel = term_reg ? CW'(cap_one(wet_reg)) : CW'(ONE_C - cap_one(wet_reg));
            end
            default:
            begin
                a_sel = '0;
                c_sel = '0;
            end
        endcase
    end

    // serial multiplier
    slg_pkg::mac_ctl_t       mac_ctl;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;

    assign mac_ctl.clear = (state_reg == S_LOAD) && !term_reg;
    assign mac_ctl.load  = (state_reg == S_LOAD);
    assign mac_ctl.step  = (state_reg == S_RUN);

    slg_mac #(
        .AW    (AW),
        .CW    (CW),
        .ACC_W (ACC_W),
        .CF    (CF)
    ) u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (a_sel),
        .c   (c_sel),
        .acc (acc)
    );

    assign rnd = acc >>> CF;

    // result arithmetic for the store cycle
    logic signed [ACC_W-1:0] atk;
    logic signed [ACC_W-1:0] t_a;
    logic signed [ACC_W-1:0] b_a;
    logic signed [ACC_W-1:0] env_new;
    logic signed [ACC_W-1:0] t_open;
    logic signed [ACC_W-1:0] b_open;

    always_comb
    begin
        atk     = (rnd < 0) ? '0 : rnd;
        t_a     = ACC_W'({1'b0, t_reg});
        b_a     = ACC_W'({1'b0, b_reg});
        t_open  = clamp_env(t_a + atk);
        b_open  = clamp_env(b_a - (atk <<< 1));
        env_new = (op_reg == OP_TDEC) ? clamp_env(b_a + rnd) : clamp_env(t_a + rnd);
    end

    logic last_store;
    logic out_free;

    assign out_free   = !out_valid_reg || out_pair.ready;
    assign last_store = (state_reg == S_DONE) && (op_reg == OP_OUT1) && out_free;

    assign in_pair.ready      = (state_reg == S_IDLE);
    assign out_pair.valid     = out_valid_reg;
    assign out_pair.left_out  = out_l_reg;
    assign out_pair.right_out = out_r_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= '0;
            treble_ret_reg <= ONE_C;
            bass_ret_reg   <= ONE_C;
            atk_step_reg   <= ATK_RST;
            wet_reg        <= ONE_C;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slg_pkg::REG_GATE_THRESHOLD: thr_reg        <= cfg_data[SB-2:0];
                slg_pkg::REG_TREBLE_RETAIN:  treble_ret_reg <= cfg_data[CF:0];
                slg_pkg::REG_BASS_RETAIN:    bass_ret_reg   <= cfg_data[CF:0];
                slg_pkg::REG_ATTACK_STEP:    atk_step_reg   <= cfg_data[CF+1:0];
                slg_pkg::REG_WET_MIX:        wet_reg        <= cfg_data[CF:0];
                default:                     thr_reg        <= thr_reg;
            endcase
        end
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ATK;
            term_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            t_reg         <= ONE_C;
            b_reg         <= '0;
            bank_sel_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                lp_reg[i] <= '0;
                hp_reg[i] <= '0;
            end
        end
        else
        begin
            // final store refills the output register in the cycle it drains
            if (last_store)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_pair.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_pair.valid)
                    begin
                        op_reg    <= OP_ATK;
                        term_reg  <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(CW - 1))
                    begin
                        term_reg  <= 1'b1;
                        state_reg <= term_reg ? S_DONE : S_LOAD;
                    end
                end
                S_DONE:
                begin
                    case (op_reg)
                        OP_ATK:
                        begin
                            if (open_reg)
                            begin
                                t_reg <= t_open[CF:0];
                                b_reg <= b_open[CF:0];
                                for (int i = 0; i < 4; i++)
                                begin
                                    lp_reg[i] <= (i % 2 == 1) ? x1_reg : x0_reg;
                                    hp_reg[i] <= '0;
                                end
                            end
                        end
                        OP_TDEC:
                        begin
                            if (!open_reg)
                            begin
                                t_reg <= env_new[CF:0];
                            end
                        end
                        OP_BDEC:
                        begin
                            if (!open_reg)
                            begin
                                b_reg <= env_new[CF:0];
                            end
                        end
                        OP_LP0, OP_LP1:
                        begin
                            lp_reg[idx] <= (t_reg >= ONE_C) ? x_ch : sat_s(rnd);
                        end
                        OP_HP0, OP_HP1:
                        begin
                            hp_reg[idx] <= (b_reg != '0) ? sat_s(rnd) : '0;
                        end
                        default:
                        begin
                            t_reg <= t_reg;
                        end
                    endcase

                    if (op_reg == OP_OUT1)
                    begin
                        if (out_free)
                        begin
                            bank_sel_reg  <= ~bank_sel_reg;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        op_reg    <= op_reg + 4'd1;
                        term_reg  <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_pair.valid && in_pair.ready)
        begin
            x0_reg   <= in_pair.left_in;
            x1_reg   <= in_pair.right_in;
            half_reg <= half_w[CF:0];
            open_reg <= (h_in > SB'(thr_reg));
        end
        if ((state_reg == S_DONE) && (op_reg == OP_OUT0))
        begin
            y0_reg <= sat_s(rnd);
        end
        if (last_store)
        begin
            out_l_reg <= y0_reg;
            out_r_reg <= sat_s(rnd);
        end
    end

endmodule
